// ===== src/mct_pkg.sv =====
// ----------------------------------------------------------------------------
// mct_pkg: shared types and helpers for the minimum-curvature trajectory block
// Holds the CORDIC word type, the unit control and status structs, the
// arctangent table and the truncate-toward-zero shift.
// ----------------------------------------------------------------------------
package mct_pkg;

   localparam int CW           = 48;
   localparam int CORDIC_STEPS = 30;
   localparam int STEP_BITS    = 5;

   typedef logic signed [CW-1:0] cword_type;

   typedef struct packed {
      logic start;
      logic vectoring;
   } cordic_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_sts_type;

   // Arctangent of 2^-i in Q30 radians.
   function automatic cword_type atan_q30(input logic [STEP_BITS-1:0] i);
      cword_type a;
      case (i)
         5'd0:    a = 48'sd843314857;
         5'd1:    a = 48'sd497837829;
         5'd2:    a = 48'sd263043837;
         5'd3:    a = 48'sd133525159;
         5'd4:    a = 48'sd67021687;
         5'd5:    a = 48'sd33543516;
         5'd6:    a = 48'sd16775851;
         5'd7:    a = 48'sd8388437;
         5'd8:    a = 48'sd4194283;
         5'd9:    a = 48'sd2097149;
         5'd10:   a = 48'sd1048576;
         5'd11:   a = 48'sd524288;
         5'd12:   a = 48'sd262144;
         5'd13:   a = 48'sd131072;
         5'd14:   a = 48'sd65536;
         5'd15:   a = 48'sd32768;
         5'd16:   a = 48'sd16384;
         5'd17:   a = 48'sd8192;
         5'd18:   a = 48'sd4096;
         5'd19:   a = 48'sd2048;
         5'd20:   a = 48'sd1024;
         5'd21:   a = 48'sd512;
         5'd22:   a = 48'sd256;
         5'd23:   a = 48'sd128;
         5'd24:   a = 48'sd64;
         5'd25:   a = 48'sd32;
         5'd26:   a = 48'sd16;
         5'd27:   a = 48'sd8;
         5'd28:   a = 48'sd4;
         5'd29:   a = 48'sd2;
         default: a = '0;
      endcase
      return a;
   endfunction

   // Arithmetic right shift that rounds toward zero instead of down.
   function automatic cword_type shr_tz(input cword_type v, input logic [STEP_BITS-1:0] n);
      logic [CW-1:0] m;
      m = v[CW-1] ? CW'(-v) : CW'(v);
      m = m >> n;
      return v[CW-1] ? cword_type'(-m) : cword_type'(m);
   endfunction

endpackage

// ===== src/mct_ifs.sv =====
// ----------------------------------------------------------------------------
// mct_ifs: valid/ready channels of the trajectory block
// One interface for survey stations and one for position results.
// ----------------------------------------------------------------------------
interface mct_req_if;
   logic        valid;
   logic        ready;
   logic [14:0] inclination_cdeg;
   logic [15:0] azimuth_cdeg;
   logic        restart;

   modport source (output valid, inclination_cdeg, azimuth_cdeg, restart, input ready);
   modport sink   (input valid, inclination_cdeg, azimuth_cdeg, restart, output ready);
endinterface

interface mct_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] north_pos;
   logic signed [31:0] east_pos;
   logic signed [31:0] vertical_pos;
   logic               saturated;

   modport source (output valid, north_pos, east_pos, vertical_pos, saturated,
                   input ready);
   modport sink   (input valid, north_pos, east_pos, vertical_pos, saturated,
                   output ready);
endinterface

// ===== src/minimum_curvature_trajectory.sv =====
// ----------------------------------------------------------------------------
// minimum_curvature_trajectory: well path by the minimum-curvature method
// Accumulates a 3-D position from a stream of survey stations.
// ----------------------------------------------------------------------------
// Usage:
//   Each transfer on req_chan is one survey station: inclination and azimuth
//   in hundredths of a degree and a restart mark. Each station yields exactly
//   one transfer on rsp_chan carrying the north, east and vertical position in
//   1/256 length unit and a flag that is set when a coordinate clipped.
//   csr_wr_en/csr_wr_data write the course length between stations; write it
//   only while no station is in flight. Reset sets it to 100 and forgets the
//   previous station, so the next one becomes the origin.
//   A first station or a restart station goes straight to the final state
//   and yields the origin. Any other station makes the sequencer run four
//   sine/cosine evaluations, two square roots, one vectoring pass and up to
//   four divisions (the chord ratio and three components). The 64-step shared
//   divider is the longest of these units.
//   req_chan.ready is high only while the sequencer is idle, so one station
//   is in work at a time. Results sit in an output register; a new station is
//   accepted while a result waits, and a finished station holds in its final
//   state until the receiver takes the previous result.
// ----------------------------------------------------------------------------
module minimum_curvature_trajectory #(
   parameter int POSITION_WIDTH = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_wr_en,
   input  logic [15:0]   csr_wr_data,
   mct_req_if.sink       req_chan,
   mct_rsp_if.source     rsp_chan
);

   localparam int PW = POSITION_WIDTH;

   // Sequencer states.
   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_RED   = 5'd1;
   localparam logic [4:0] S_AMUL  = 5'd2;
   localparam logic [4:0] S_ADIV  = 5'd3;
   localparam logic [4:0] S_AWAIT = 5'd4;
   localparam logic [4:0] S_ACOR  = 5'd5;
   localparam logic [4:0] S_CWAIT = 5'd6;
   localparam logic [4:0] S_UX    = 5'd7;
   localparam logic [4:0] S_UY    = 5'd8;
   localparam logic [4:0] S_UZ    = 5'd9;
   localparam logic [4:0] S_SQMUL = 5'd10;
   localparam logic [4:0] S_SQACC = 5'd11;
   localparam logic [4:0] S_RTC   = 5'd12;
   localparam logic [4:0] S_RTCW  = 5'd13;
   localparam logic [4:0] S_RTD   = 5'd14;
   localparam logic [4:0] S_RTDW  = 5'd15;
   localparam logic [4:0] S_VEC   = 5'd16;
   localparam logic [4:0] S_VECW  = 5'd17;
   localparam logic [4:0] S_RDIV  = 5'd18;
   localparam logic [4:0] S_RDIVW = 5'd19;
   localparam logic [4:0] S_CMUL  = 5'd20;
   localparam logic [4:0] S_CDIV  = 5'd21;
   localparam logic [4:0] S_CDIVW = 5'd22;
   localparam logic [4:0] S_CSCL  = 5'd23;
   localparam logic [4:0] S_CDISP = 5'd24;
   localparam logic [4:0] S_CACC  = 5'd25;
   localparam logic [4:0] S_DONE  = 5'd26;

   localparam logic [15:0]        CL_RESET       = 16'd100;
   localparam logic [15:0]        FULL_TURN      = 16'd36000;
   localparam logic [15:0]        QUARTER_TURN   = 16'd9000;
   localparam logic [15:0]        HALF_TURN      = 16'd18000;
   localparam logic [15:0]        THREE_QUARTERS = 16'd27000;
   // Pi in Q30 split as 18000 * ANGLE_WHOLE + ANGLE_PART, so the angle is
   // rem * ANGLE_WHOLE plus the rounded quotient of rem * ANGLE_PART by 18000.
   // That small quotient comes from a reciprocal multiply on the value
   // shifted right by four (18000 = 16 * 1125), exact over the whole range.
   localparam logic [17:0]        ANGLE_WHOLE    = 18'd187403;
   localparam logic [12:0]        ANGLE_PART     = 13'd5426;
   localparam logic [25:0]        ANGLE_ROUND    = 26'd9000;
   localparam logic [22:0]        ANGLE_RECIP    = 23'd7635498;
   localparam logic [30:0]        Q30_ONE        = 31'h4000_0000;
   localparam logic [46:0]        DISP_ROUND     = 47'd2097152;
   localparam logic signed [mct_pkg::CW-1:0] CORDIC_START = 48'sd652032874;
   localparam logic signed [63:0] POS_HI = (64'sd1 <<< (PW - 1)) - 64'sd1;
   localparam logic signed [63:0] POS_LO = -POS_HI - 64'sd1;

   // Q30 product scaled back with truncation toward zero.
   function automatic logic signed [32:0] q30_tz(input logic signed [67:0] p);
      logic [67:0] m;
      logic [32:0] t;
      m = p[67] ? 68'(-p) : 68'(p);
      m = m >> 30;
      t = m[32:0];
      return p[67] ? signed'(-t) : signed'(t);
   endfunction

   // Control state.
   logic [4:0]          state_ff, state_in;
   logic [1:0]          sel_ff, sel_in;
   logic [1:0]          k_ff, k_in;
   logic                dsel_ff, dsel_in;
   logic                have_prev_ff, have_prev_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [15:0]         cl_ff, cl_in;
   logic [14:0]         prev_inc_ff, prev_inc_in;
   logic [15:0]         prev_az_ff, prev_az_in;
   logic signed [PW-1:0] acc_ff [3];
   logic signed [PW-1:0] acc_in [3];

   // Working registers.
   logic [14:0]          cur_inc_ff, cur_inc_in;
   logic [15:0]          cur_az_ff, cur_az_in;
   logic [13:0]          rem_ff, rem_in;
   logic [1:0]           quad_ff, quad_in;
   logic [11:0]          frac_ff, frac_in;
   logic signed [32:0]   si_ff, si_in, ci_ff, ci_in, sa_ff, sa_in, ca_ff, ca_in;
   logic signed [32:0]   u_ff [2][3];
   logic signed [32:0]   u_in [2][3];
   logic [63:0]          csq_ff, csq_in, dsq_ff, dsq_in;
   logic [31:0]          cn_ff, cn_in, dn_ff, dn_in;
   logic [30:0]          r_ff, r_in, q_ff, q_in;
   logic signed [25:0]   disp_ff, disp_in;
   logic                 sat_ff, sat_in;
   logic signed [67:0]   prod_ff;
   logic signed [31:0]   out_n_ff, out_n_in, out_e_ff, out_e_in, out_v_ff, out_v_in;
   logic                 out_s_ff, out_s_in;

   // Datapath nets.
   logic signed [33:0]   mul_a, mul_b;
   logic signed [33:0]   cs [3];
   logic signed [33:0]   ds [3];
   logic signed [33:0]   cs_k, cs_abs, sq_op;
   logic [15:0]          ang, ang_red;
   logic [25:0]          angle_n;
   logic signed [32:0]   cor_c, cor_s, cx, cy;
   logic [24:0]          disp_mag;
   logic [46:0]          disp_sum;
   logic signed [63:0]   acc_sum;
   logic signed [63:0]   ext [3];
   logic                 load_out;

   // Shared units.
   logic                   div_start;
   logic [63:0]            div_dividend, div_quot;
   logic [33:0]            div_divisor;
   mct_pkg::unit_sts_type  div_sts;
   logic                   sq_start;
   logic [63:0]            sq_value;
   logic [31:0]            sq_root;
   mct_pkg::unit_sts_type  sq_sts;
   mct_pkg::cordic_ctl_type cor_ctl;
   mct_pkg::cword_type     cor_x0, cor_y0, cor_z0, cor_x, cor_y, cor_z;
   mct_pkg::unit_sts_type  cor_sts;

   mct_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .sts      (div_sts),
      .quotient (div_quot)
   );

   mct_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .value (sq_value),
      .sts   (sq_sts),
      .root  (sq_root)
   );

   mct_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .ctl   (cor_ctl),
      .x0    (cor_x0),
      .y0    (cor_y0),
      .z0    (cor_z0),
      .sts   (cor_sts),
      .x     (cor_x),
      .y     (cor_y),
      .z     (cor_z)
   );

   // Chord direction and difference of the two station unit vectors.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cs[i]  = 34'(u_ff[0][i]) + 34'(u_ff[1][i]);
         ds[i]  = 34'(u_ff[0][i]) - 34'(u_ff[1][i]);
         ext[i] = 64'(acc_ff[i]);
      end
   end

   assign cs_k   = cs[k_ff];
   assign cs_abs = cs_k[33] ? -cs_k : cs_k;
   assign sq_op  = dsel_ff ? ds[k_ff] : cs[k_ff];

   // Angle selection and reduction to one turn: previous station first.
   always_comb begin
      case (sel_ff)
         2'd0:    ang = {1'b0, prev_inc_ff};
         2'd1:    ang = prev_az_ff;
         2'd2:    ang = {1'b0, cur_inc_ff};
         default: ang = cur_az_ff;
      endcase
      ang_red = (ang >= FULL_TURN) ? ang - FULL_TURN : ang;
   end

   // Rounded remainder product of the angle conversion.
   assign angle_n = prod_ff[25:0] + ANGLE_ROUND;

   // Quadrant fold of the rotation result.
   assign cx = cor_x[32:0];
   assign cy = cor_y[32:0];
   always_comb begin
      case (quad_ff)
         2'd0: begin
            cor_c = cx;
            cor_s = cy;
         end
         2'd1: begin
            cor_c = -cy;
            cor_s = cx;
         end
         2'd2: begin
            cor_c = -cx;
            cor_s = -cy;
         end
         default: begin
            cor_c = cy;
            cor_s = -cx;
         end
      endcase
   end

   assign disp_sum = prod_ff[46:0] + DISP_ROUND;
   assign disp_mag = disp_sum[46:22];
   assign acc_sum  = ext[k_ff] + 64'(disp_ff);
   assign load_out = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      sel_in       = sel_ff;
      k_in         = k_ff;
      dsel_in      = dsel_ff;
      have_prev_in = have_prev_ff;
      cl_in        = csr_wr_en ? csr_wr_data : cl_ff;
      prev_inc_in  = prev_inc_ff;
      prev_az_in   = prev_az_ff;
      acc_in       = acc_ff;
      cur_inc_in   = cur_inc_ff;
      cur_az_in    = cur_az_ff;
      rem_in       = rem_ff;
      quad_in      = quad_ff;
      frac_in      = frac_ff;
      si_in        = si_ff;
      ci_in        = ci_ff;
      sa_in        = sa_ff;
      ca_in        = ca_ff;
      u_in         = u_ff;
      csq_in       = csq_ff;
      dsq_in       = dsq_ff;
      cn_in        = cn_ff;
      dn_in        = dn_ff;
      r_in         = r_ff;
      q_in         = q_ff;
      disp_in      = disp_ff;
      sat_in       = sat_ff;
      mul_a        = '0;
      mul_b        = '0;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      sq_start     = 1'b0;
      sq_value     = '0;
      cor_ctl      = '0;
      cor_x0       = '0;
      cor_y0       = '0;
      cor_z0       = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               cur_inc_in = req_chan.inclination_cdeg;
               cur_az_in  = req_chan.azimuth_cdeg;
               sat_in     = 1'b0;
               if (!have_prev_ff || req_chan.restart) begin
                  for (int i = 0; i < 3; i++) acc_in[i] = '0;
                  state_in = S_DONE;
               end else begin
                  sel_in   = 2'd0;
                  state_in = S_RED;
               end
            end
         end
         S_RED: begin
            if (ang_red >= THREE_QUARTERS) begin
               quad_in = 2'd3;
               rem_in  = 14'(ang_red - THREE_QUARTERS);
            end else if (ang_red >= HALF_TURN) begin
               quad_in = 2'd2;
               rem_in  = 14'(ang_red - HALF_TURN);
            end else if (ang_red >= QUARTER_TURN) begin
               quad_in = 2'd1;
               rem_in  = 14'(ang_red - QUARTER_TURN);
            end else begin
               quad_in = 2'd0;
               rem_in  = 14'(ang_red);
            end
            state_in = S_AMUL;
         end
         S_AMUL: begin
            mul_a    = signed'({20'd0, rem_ff});
            mul_b    = signed'({21'd0, ANGLE_PART});
            state_in = S_ADIV;
         end
         S_ADIV: begin
            mul_a    = signed'({12'd0, angle_n[25:4]});
            mul_b    = signed'({11'd0, ANGLE_RECIP});
            state_in = S_AWAIT;
         end
         S_AWAIT: begin
            frac_in  = prod_ff[44:33];
            mul_a    = signed'({20'd0, rem_ff});
            mul_b    = signed'({16'd0, ANGLE_WHOLE});
            state_in = S_ACOR;
         end
         S_ACOR: begin
            cor_ctl.start     = 1'b1;
            cor_ctl.vectoring = 1'b0;
            cor_x0            = CORDIC_START;
            cor_y0            = '0;
            cor_z0            = mct_pkg::cword_type'({16'd0, prod_ff[31:0]}) +
                                mct_pkg::cword_type'({36'd0, frac_ff});
            state_in          = S_CWAIT;
         end
         S_CWAIT: begin
            if (cor_sts.done) begin
               if (!sel_ff[0]) begin
                  si_in    = cor_s;
                  ci_in    = cor_c;
                  sel_in   = sel_ff + 2'd1;
                  state_in = S_RED;
               end else begin
                  sa_in    = cor_s;
                  ca_in    = cor_c;
                  state_in = S_UX;
               end
            end
         end
         S_UX: begin
            mul_a    = 34'(si_ff);
            mul_b    = 34'(ca_ff);
            state_in = S_UY;
         end
         S_UY: begin
            u_in[sel_ff[1]][0] = q30_tz(prod_ff);
            mul_a              = 34'(si_ff);
            mul_b              = 34'(sa_ff);
            state_in           = S_UZ;
         end
         S_UZ: begin
            u_in[sel_ff[1]][1] = q30_tz(prod_ff);
            u_in[sel_ff[1]][2] = ci_ff;
            if (sel_ff == 2'd3) begin
               k_in     = 2'd0;
               dsel_in  = 1'b0;
               csq_in   = '0;
               dsq_in   = '0;
               state_in = S_SQMUL;
            end else begin
               sel_in   = sel_ff + 2'd1;
               state_in = S_RED;
            end
         end
         S_SQMUL: begin
            mul_a    = sq_op;
            mul_b    = sq_op;
            state_in = S_SQACC;
         end
         S_SQACC: begin
            if (dsel_ff) dsq_in = dsq_ff + prod_ff[63:0];
            else         csq_in = csq_ff + prod_ff[63:0];
            if (k_ff == 2'd2) begin
               k_in     = 2'd0;
               dsel_in  = 1'b1;
               state_in = dsel_ff ? S_RTC : S_SQMUL;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = S_SQMUL;
            end
         end
         S_RTC: begin
            sq_start = 1'b1;
            sq_value = csq_ff;
            state_in = S_RTCW;
         end
         S_RTCW: begin
            if (sq_sts.done) begin
               cn_in    = sq_root;
               state_in = S_RTD;
            end
         end
         S_RTD: begin
            sq_start = 1'b1;
            sq_value = dsq_ff;
            state_in = S_RTDW;
         end
         S_RTDW: begin
            if (sq_sts.done) begin
               dn_in = sq_root;
               // Opposite stations: no displacement at all.
               state_in = (cn_ff == '0) ? S_DONE : S_VEC;
            end
         end
         S_VEC: begin
            cor_ctl.start     = 1'b1;
            cor_ctl.vectoring = 1'b1;
            cor_x0            = mct_pkg::cword_type'({16'd0, cn_ff});
            cor_y0            = mct_pkg::cword_type'({16'd0, dn_ff});
            cor_z0            = '0;
            state_in          = S_VECW;
         end
         S_VECW: begin
            if (cor_sts.done) begin
               k_in = 2'd0;
               if (cor_z <= 0) begin
                  // Zero dogleg: sin(h)/h tends to one.
                  r_in     = Q30_ONE;
                  state_in = S_CMUL;
               end else begin
                  state_in = S_RDIV;
               end
            end
         end
         S_RDIV: begin
            div_start    = 1'b1;
            div_dividend = {3'd0, dn_ff, 29'd0};
            div_divisor  = cor_z[33:0];
            state_in     = S_RDIVW;
         end
         S_RDIVW: begin
            if (div_sts.done) begin
               r_in     = (div_quot > 64'(Q30_ONE)) ? Q30_ONE : div_quot[30:0];
               state_in = S_CMUL;
            end
         end
         S_CMUL: begin
            mul_a    = cs_abs;
            mul_b    = signed'({3'd0, r_ff});
            state_in = S_CDIV;
         end
         S_CDIV: begin
            div_start    = 1'b1;
            div_dividend = prod_ff[63:0];
            div_divisor  = {2'd0, cn_ff};
            state_in     = S_CDIVW;
         end
         S_CDIVW: begin
            if (div_sts.done) begin
               q_in     = div_quot[30:0];
               state_in = S_CSCL;
            end
         end
         S_CSCL: begin
            mul_a    = signed'({3'd0, q_ff});
            mul_b    = signed'({18'd0, cl_ff});
            state_in = S_CDISP;
         end
         S_CDISP: begin
            disp_in  = cs_k[33] ? -signed'({1'b0, disp_mag}) : signed'({1'b0, disp_mag});
            state_in = S_CACC;
         end
         S_CACC: begin
            if (acc_sum > POS_HI) begin
               acc_in[k_ff] = POS_HI[PW-1:0];
               sat_in       = 1'b1;
            end else if (acc_sum < POS_LO) begin
               acc_in[k_ff] = POS_LO[PW-1:0];
               sat_in       = 1'b1;
            end else begin
               acc_in[k_ff] = acc_sum[PW-1:0];
            end
            if (k_ff == 2'd2) begin
               state_in = S_DONE;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = S_CMUL;
            end
         end
         S_DONE: begin
            if (load_out) begin
               prev_inc_in  = cur_inc_ff;
               prev_az_in   = cur_az_ff;
               have_prev_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register: loaded from the accumulators when a station finishes.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      out_n_in     = out_n_ff;
      out_e_in     = out_e_ff;
      out_v_in     = out_v_ff;
      out_s_in     = out_s_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         out_n_in     = ext[0][31:0];
         out_e_in     = ext[1][31:0];
         out_v_in     = ext[2][31:0];
         out_s_in     = sat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sel_ff       <= '0;
         k_ff         <= '0;
         dsel_ff      <= 1'b0;
         have_prev_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cl_ff        <= CL_RESET;
         prev_inc_ff  <= '0;
         prev_az_ff   <= '0;
         for (int i = 0; i < 3; i++) acc_ff[i] <= '0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         k_ff         <= k_in;
         dsel_ff      <= dsel_in;
         have_prev_ff <= have_prev_in;
         rsp_valid_ff <= rsp_valid_in;
         cl_ff        <= cl_in;
         prev_inc_ff  <= prev_inc_in;
         prev_az_ff   <= prev_az_in;
         acc_ff       <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_inc_ff <= cur_inc_in;
      cur_az_ff  <= cur_az_in;
      rem_ff     <= rem_in;
      quad_ff    <= quad_in;
      frac_ff    <= frac_in;
      si_ff      <= si_in;
      ci_ff      <= ci_in;
      sa_ff      <= sa_in;
      ca_ff      <= ca_in;
      u_ff       <= u_in;
      csq_ff     <= csq_in;
      dsq_ff     <= dsq_in;
      cn_ff      <= cn_in;
      dn_ff      <= dn_in;
      r_ff       <= r_in;
      q_ff       <= q_in;
      disp_ff    <= disp_in;
      sat_ff     <= sat_in;
      prod_ff    <= 68'(mul_a) * 68'(mul_b);
      out_n_ff   <= out_n_in;
      out_e_ff   <= out_e_in;
      out_v_ff   <= out_v_in;
      out_s_ff   <= out_s_in;
   end

   assign req_chan.ready        = (state_ff == S_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.north_pos    = out_n_ff;
   assign rsp_chan.east_pos     = out_e_ff;
   assign rsp_chan.vertical_pos = out_v_ff;
   assign rsp_chan.saturated    = out_s_ff;

   // The sequencer never restarts a shared unit that is still iterating.
   a_cordic_free: assert property (@(posedge clock) disable iff (reset)
      cor_ctl.start |-> !cor_sts.busy)
      else $error("CORDIC started while busy");

   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_sts.busy)
      else $error("divider started while busy");

   // The chord ratio never exceeds one in Q30.
   a_ratio_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMUL) |-> (r_ff <= Q30_ONE))
      else $error("chord ratio above one");

   // A restart station puts the position back at the origin at once.
   a_restart_origin: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.restart) |=>
         (acc_ff[0] == '0 && acc_ff[1] == '0 && acc_ff[2] == '0))
      else $error("restart did not clear the position");

endmodule

// ===== src/mct_cordic.sv =====
// ----------------------------------------------------------------------------
// mct_cordic: shared CORDIC unit, one micro-rotation per cycle
// Rotation mode drives z to zero; vectoring mode drives y to zero.
// ----------------------------------------------------------------------------
module mct_cordic (
   input  logic                       clock,
   input  logic                       reset,
   input  mct_pkg::cordic_ctl_type    ctl,
   input  mct_pkg::cword_type         x0,
   input  mct_pkg::cword_type         y0,
   input  mct_pkg::cword_type         z0,
   output mct_pkg::unit_sts_type      sts,
   output mct_pkg::cword_type         x,
   output mct_pkg::cword_type         y,
   output mct_pkg::cword_type         z
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic                              vec_ff, vec_in;
   logic [mct_pkg::STEP_BITS-1:0]     i_ff, i_in;
   mct_pkg::cword_type                x_ff, x_in, y_ff, y_in, z_ff, z_in;
   mct_pkg::cword_type                dx, dy, ang;
   logic                              plus, minus;

   always_comb begin
      dx    = mct_pkg::shr_tz(x_ff, i_ff);
      dy    = mct_pkg::shr_tz(y_ff, i_ff);
      ang   = mct_pkg::atan_q30(i_ff);
      plus  = vec_ff ? (y_ff < 0) : (z_ff >= 0);
      minus = vec_ff ? (y_ff > 0) : (z_ff < 0);
      busy_in = busy_ff;
      done_in = 1'b0;
      vec_in  = vec_ff;
      i_in    = i_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         vec_in  = ctl.vectoring;
         i_in    = '0;
         x_in    = x0;
         y_in    = y0;
         z_in    = z0;
      end else if (busy_ff) begin
         if (plus) begin
            x_in = x_ff - dy;
            y_in = y_ff + dx;
            z_in = z_ff - ang;
         end else if (minus) begin
            x_in = x_ff + dy;
            y_in = y_ff - dx;
            z_in = z_ff + ang;
         end
         i_in = i_ff + 1'b1;
         if (i_ff == mct_pkg::STEP_BITS'(mct_pkg::CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         vec_ff  <= 1'b0;
         i_ff    <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         vec_ff  <= vec_in;
         i_ff    <= i_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign x = x_ff;
   assign y = y_ff;
   assign z = z_ff;

endmodule

// ===== src/mct_div.sv =====
// ----------------------------------------------------------------------------
// mct_div: restoring divider, one quotient bit per cycle
// Divides a 64-bit unsigned dividend by a 34-bit unsigned nonzero divisor.
// ----------------------------------------------------------------------------
module mct_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [63:0]           dividend,
   input  logic [33:0]           divisor,
   output mct_pkg::unit_sts_type sts,
   output logic [63:0]           quotient
);

   localparam int DIV_STEPS = 64;
   localparam int CNT_BITS  = $clog2(DIV_STEPS);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [63:0]         quo_ff, quo_in;
   logic [33:0]         rem_ff, rem_in;
   logic [33:0]         dvs_ff, dvs_in;
   logic [34:0]         rem_sh, rem_sub;
   logic                ge;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[63]};
      rem_sub = rem_sh - {1'b0, dvs_ff};
      ge      = (rem_sh >= {1'b0, dvs_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? rem_sub[33:0] : rem_sh[33:0];
         quo_in = {quo_ff[62:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_BITS'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== src/mct_isqrt.sv =====
// ----------------------------------------------------------------------------
// mct_isqrt: floor square root of a 64-bit value, two radicand bits per cycle
// Digit-by-digit method; the root settles after 32 steps.
// ----------------------------------------------------------------------------
module mct_isqrt (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [63:0]           value,
   output mct_pkg::unit_sts_type sts,
   output logic [31:0]           root
);

   localparam int SQRT_STEPS = 32;
   localparam int CNT_BITS   = $clog2(SQRT_STEPS);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [63:0]         v_ff, v_in, res_ff, res_in, bit_ff, bit_in;
   logic [63:0]         trial;
   logic                ge;

   always_comb begin
      trial   = res_ff + bit_ff;
      ge      = (v_ff >= trial);
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      v_in    = v_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         v_in    = value;
         res_in  = '0;
         bit_in  = 64'h4000_0000_0000_0000;
      end else if (busy_ff) begin
         v_in   = ge ? v_ff - trial : v_ff;
         res_in = ge ? (res_ff >> 1) + bit_ff : res_ff >> 1;
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_BITS'(SQRT_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff   <= v_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign root     = res_ff[31:0];

endmodule

// ===== test/mct_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mct_checker: position predictor and result checker for the trajectory block
// Watches the station, result and course length ports. Every accepted station
// is run through a fixed-point minimum-curvature predictor, and every accepted
// result is compared field by field with the oldest predicted position.
// ----------------------------------------------------------------------------
module mct_checker (
   input  logic      clock,
   input  logic      reset,
   input  logic      csr_wr_en,
   input  logic [15:0] csr_wr_data,
   mct_req_if        req_mon,
   mct_rsp_if        rsp_mon,
   output int        error_count,
   output int        pending_count
);

   localparam longint PI_Q30     = 64'sd3373259426;
   localparam longint Q30_ONE    = 64'sd1073741824;
   localparam longint CORDIC_X0  = 64'sd652032874;
   localparam longint POS_HI     = 64'sd2147483647;
   localparam longint POS_LO     = -64'sd2147483648;

   typedef struct packed {
      logic signed [31:0] north;
      logic signed [31:0] east;
      logic signed [31:0] vertical;
      logic               saturated;
   } position_type;

   position_type expected_positions[$];

   logic [15:0]  course_len;
   logic [14:0]  last_inclination;
   logic [15:0]  last_azimuth;
   longint       north_sum, east_sum, vertical_sum;
   logic         track_open;

   longint arctan_table[30] = '{
      843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
      65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
      16, 8, 4, 2};

   function automatic longint trunc_shift(longint v, int n);
      if (v < 0) return -((-v) >>> n);
      return v >>> n;
   endfunction

   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned res, bit_w;
      res = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > v) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
         if (v >= res + bit_w) begin
            v = v - (res + bit_w);
            res = (res >> 1) + bit_w;
         end else begin
            res = res >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return res;
   endfunction

   // Rotation CORDIC after folding the angle into its quadrant.
   function automatic void sine_cosine(longint unsigned cdeg, output longint s,
                                       output longint c);
      longint unsigned a, quad, rem;
      longint z, x, y, nx;
      a = cdeg % 36000;
      quad = a / 9000;
      rem = a % 9000;
      z = longint'((rem * longint'(PI_Q30) + 9000) / 18000);
      x = CORDIC_X0;
      y = 0;
      for (int i = 0; i < 30; i++) begin
         if (z >= 0) begin
            nx = x - trunc_shift(y, i);
            y  = y + trunc_shift(x, i);
            z  = z - arctan_table[i];
         end else begin
            nx = x + trunc_shift(y, i);
            y  = y - trunc_shift(x, i);
            z  = z + arctan_table[i];
         end
         x = nx;
      end
      case (quad)
         0: begin c = x;  s = y;  end
         1: begin c = -y; s = x;  end
         2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endfunction

   // Vectoring CORDIC; a step that finds y already zero leaves things alone.
   function automatic longint half_dogleg(longint x, longint y);
      longint z, nx;
      z = 0;
      for (int i = 0; i < 30; i++) begin
         if (y > 0) begin
            nx = x + trunc_shift(y, i);
            y  = y - trunc_shift(x, i);
            z  = z + arctan_table[i];
         end else if (y < 0) begin
            nx = x - trunc_shift(y, i);
            y  = y + trunc_shift(x, i);
            z  = z - arctan_table[i];
         end else begin
            nx = x;
         end
         x = nx;
      end
      return z;
   endfunction

   function automatic void station_direction(longint unsigned inc, longint unsigned az,
                                             output longint u[3]);
      longint si, ci, sa, ca;
      sine_cosine(inc, si, ci);
      sine_cosine(az, sa, ca);
      u[0] = trunc_shift(si * ca, 30);
      u[1] = trunc_shift(si * sa, 30);
      u[2] = ci;
   endfunction

   function automatic longint clip_position(longint acc, longint d, ref logic sat);
      longint v;
      v = acc + d;
      if (v > POS_HI) begin sat = 1'b1; return POS_HI; end
      if (v < POS_LO) begin sat = 1'b1; return POS_LO; end
      return v;
   endfunction

   // Moves the running position along the chord to the new station.
   function automatic position_type advance_track(logic [14:0] inc, logic [15:0] az,
                                                  logic restart_mark);
      longint u1[3], u2[3], sums[3], diffs[3], disp[3];
      longint unsigned sum_sq, diff_sq, sum_norm, diff_norm, ratio, mag, q, d;
      longint h;
      logic sat;
      position_type p;
      sat = 1'b0;
      disp = '{0, 0, 0};
      if (!track_open || restart_mark) begin
         north_sum = 0;
         east_sum = 0;
         vertical_sum = 0;
      end else begin
         station_direction(last_inclination, last_azimuth, u1);
         station_direction(inc, az, u2);
         sum_sq = 0;
         diff_sq = 0;
         for (int k = 0; k < 3; k++) begin
            sums[k]  = u1[k] + u2[k];
            diffs[k] = u1[k] - u2[k];
            sum_sq  += longint'(sums[k] * sums[k]);
            diff_sq += longint'(diffs[k] * diffs[k]);
         end
         sum_norm = floor_sqrt(sum_sq);
         diff_norm = floor_sqrt(diff_sq);
         if (sum_norm != 0) begin
            h = half_dogleg(longint'(sum_norm), longint'(diff_norm));
            if (h <= 0) begin
               ratio = Q30_ONE;
            end else begin
               ratio = (diff_norm << 29) / longint'(h);
               if (ratio > Q30_ONE) ratio = Q30_ONE;
            end
            for (int k = 0; k < 3; k++) begin
               mag = (sums[k] < 0) ? -sums[k] : sums[k];
               q = (mag * ratio) / sum_norm;
               d = (q * course_len + (64'd1 << 21)) >> 22;
               disp[k] = (sums[k] < 0) ? -longint'(d) : longint'(d);
            end
         end
         north_sum    = clip_position(north_sum, disp[0], sat);
         east_sum     = clip_position(east_sum, disp[1], sat);
         vertical_sum = clip_position(vertical_sum, disp[2], sat);
      end
      last_inclination = inc;
      last_azimuth = az;
      track_open = 1'b1;
      p.north = north_sum[31:0];
      p.east = east_sum[31:0];
      p.vertical = vertical_sum[31:0];
      p.saturated = sat;
      return p;
   endfunction

   always @(posedge clock) begin
      position_type want;
      if (reset) begin
         course_len <= 16'd100;
         last_inclination = '0;
         last_azimuth = '0;
         north_sum = 0;
         east_sum = 0;
         vertical_sum = 0;
         track_open = 1'b0;
         expected_positions.delete();
         error_count <= 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            expected_positions.push_back(advance_track(req_mon.inclination_cdeg,
               req_mon.azimuth_cdeg, req_mon.restart));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_positions.size() == 0) begin
               $display("%0t: result transfer with nothing expected: n=%0d e=%0d v=%0d s=%0b",
                  $time, rsp_mon.north_pos, rsp_mon.east_pos, rsp_mon.vertical_pos,
                  rsp_mon.saturated);
               error_count <= error_count + 1;
            end else begin
               want = expected_positions.pop_front();
               if (want.north !== rsp_mon.north_pos || want.east !== rsp_mon.east_pos ||
                   want.vertical !== rsp_mon.vertical_pos ||
                   want.saturated !== rsp_mon.saturated) begin
                  $display("%0t: position mismatch expected n=%0d e=%0d v=%0d s=%0b",
                     $time, want.north, want.east, want.vertical, want.saturated);
                  $display("%0t:                   actual   n=%0d e=%0d v=%0d s=%0b",
                     $time, rsp_mon.north_pos, rsp_mon.east_pos, rsp_mon.vertical_pos,
                     rsp_mon.saturated);
                  error_count <= error_count + 1;
               end
            end
         end
         if (csr_wr_en) course_len <= csr_wr_data;
      end
      pending_count <= expected_positions.size();
   end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the minimum-curvature trajectory block
// Sends directed survey stations, long straight runs, then phases of random
// tracks under several course lengths, with random gaps on both channels and
// a checker module that predicts every position.
// ----------------------------------------------------------------------------
module tb_top;

   // The slowest correct run sends 1480 stations, plus stalls; the limit leaves
   // a wide margin over that.
   localparam int CYCLE_LIMIT = 20000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;
   int          error_count;
   int          pending_count;
   int          cycle_count = 0;
   int          sink_stall = 0;
   logic        sink_busy_mode = 1'b1;
   logic [14:0] track_inclination = '0;
   logic [15:0] track_azimuth = '0;

   mct_req_if req_chan ();
   mct_rsp_if rsp_chan ();

   minimum_curvature_trajectory u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan.sink),
      .rsp_chan    (rsp_chan.source)
   );

   mct_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   always #5 clock = ~clock;

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Result side back-pressure. Busy mode stalls now and then, mostly briefly
   // and occasionally for a long stretch; calm mode only finishes such a stall.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if ($urandom_range(0, 999) == 0) sink_busy_mode <= ~sink_busy_mode;
         if (sink_stall > 0) begin
            sink_stall <= sink_stall - 1;
            rsp_chan.ready <= 1'b0;
         end else if (sink_busy_mode && $urandom_range(0, 3) == 0) begin
            sink_stall <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200)
                                                      : $urandom_range(0, 3);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 95) return $urandom_range(1, 4);
      return $urandom_range(20, 300);
   endfunction

   // One station transfer. The valid line is lowered only when a gap follows,
   // so it never gets two assignments in the same time step.
   task automatic send_station(input logic [14:0] inc, input logic [15:0] az,
                               input logic restart_mark);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.inclination_cdeg <= inc;
      req_chan.azimuth_cdeg <= az;
      req_chan.restart <= restart_mark;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Drains every outstanding result, then writes the course length while the
   // block sits idle.
   task automatic set_course_length(input logic [15:0] value);
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // A realistic track drifts a little between stations; the rest of the
   // time the station is anywhere in range or even raw noise on every bit.
   task automatic send_random_station();
      int roll;
      logic [14:0] inc;
      logic [15:0] az;
      roll = $urandom_range(0, 99);
      if (roll < 65) begin
         inc = 15'((int'(track_inclination) + $urandom_range(0, 1200) + 18000 - 600) % 18001);
         az = 16'((int'(track_azimuth) + $urandom_range(0, 2000) + 36000 - 1000) % 36000);
      end else if (roll < 90) begin
         inc = 15'($urandom_range(0, 18000));
         az = 16'($urandom_range(0, 35999));
      end else begin
         inc = 15'($urandom);
         az = 16'($urandom);
      end
      track_inclination = 15'(int'(inc) % 18001);
      track_azimuth = 16'(int'(az) % 36000);
      send_station(inc, az, $urandom_range(0, 19) == 0);
   endtask

   initial begin
      logic [15:0] course_choices[5];
      req_chan.valid = 1'b0;
      req_chan.inclination_cdeg = '0;
      req_chan.azimuth_cdeg = '0;
      req_chan.restart = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed stations: origin, zero dogleg, quadrants, opposite stations,
      // angles past a full turn, field extremes and restarts.
      send_station(15'd0, 16'd0, 1'b1);
      send_station(15'd0, 16'd0, 1'b0);
      send_station(15'd9000, 16'd0, 1'b0);
      send_station(15'd9000, 16'd9000, 1'b0);
      send_station(15'd9000, 16'd18000, 1'b0);
      send_station(15'd9000, 16'd27000, 1'b0);
      send_station(15'd9000, 16'd35999, 1'b0);
      send_station(15'd18000, 16'd0, 1'b0);
      send_station(15'd0, 16'd0, 1'b0);
      send_station(15'd32767, 16'd65535, 1'b0);
      send_station(15'd0, 16'd0, 1'b0);
      send_station(15'd4500, 16'd12345, 1'b1);
      send_station(15'd4500, 16'd12345, 1'b0);
      send_station(15'd27000, 16'd45000, 1'b0);
      send_station(15'd9000, 16'd9000, 1'b0);
      send_station(15'd9000, 16'd27000, 1'b0);

      set_course_length(16'd0);
      send_station(15'd3000, 16'd100, 1'b0);
      send_station(15'd6000, 16'd200, 1'b0);

      // Long straight runs at the widest course length drive the vertical
      // position far up and then far down.
      set_course_length(16'd65535);
      send_station(15'd0, 16'd0, 1'b1);
      repeat (80) send_station(15'd0, 16'(($urandom_range(0, 35999))), 1'b0);
      send_station(15'd18000, 16'd0, 1'b1);
      repeat (80) send_station(15'd18000, 16'(($urandom_range(0, 35999))), 1'b0);

      course_choices = '{16'd1, 16'd65535, 16'd0, 16'd100, 16'd0};
      for (int phase = 0; phase < 10; phase++) begin
         course_choices[4] = 16'($urandom);
         set_course_length(course_choices[$urandom_range(0, 4)]);
         repeat (130) send_random_station();
      end

      // Ends the run, waiting out results still in flight.
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
